// ===== hdl/pca_pkg.sv =====
// Shared types, constants and lookup functions for the packed counter array.
package pca_pkg;

	localparam int TYPE_W  = 2;
	localparam int IDX_W   = 15;
	localparam int DATA_W  = 32;
	localparam int RANGE_W = 16;
	localparam int WID_W   = 6;
	localparam int CNT_W   = 16;
	localparam int RCP_W   = 22;
	// quotient taken from idx * ceil(2^RCP_SH / per_word); exact for 15-bit indexes
	localparam int RCP_SH  = 21;

	typedef enum logic [TYPE_W-1:0] {
		REQ_FILL = 2'd0,
		REQ_SET  = 2'd1,
		REQ_READ = 2'd2,
		REQ_INC  = 2'd3
	} req_kind_t;

	typedef enum logic [0:0] {
		CFG_WIDTH = 1'b0,
		CFG_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SWEEP = 9'b000000010,
		ST_BUILD = 9'b000000100,
		ST_DIV   = 9'b000001000,
		ST_MUL   = 9'b000010000,
		ST_REM   = 9'b000100000,
		ST_RD    = 9'b001000000,
		ST_UPD   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	// Counters per 32-bit word for an effective width of 1..32.
	function automatic logic [WID_W-1:0] per_word(input logic [WID_W-1:0] w);
		logic [WID_W-1:0] p;
		case (w)
			6'd1:  p = 6'd32;
			6'd2:  p = 6'd16;
			6'd3:  p = 6'd10;
			6'd4:  p = 6'd8;
			6'd5:  p = 6'd6;
			6'd6:  p = 6'd5;
			6'd7, 6'd8: p = 6'd4;
			6'd9, 6'd10: p = 6'd3;
			6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16: p = 6'd2;
			default: p = 6'd1;
		endcase
		return p;
	endfunction

	// ceil(2^21 / p) for each per-word count that can occur.
	function automatic logic [RCP_W-1:0] recip(input logic [WID_W-1:0] p);
		logic [RCP_W-1:0] r;
		case (p)
			6'd32:   r = 22'd65536;
			6'd16:   r = 22'd131072;
			6'd10:   r = 22'd209716;
			6'd8:    r = 22'd262144;
			6'd6:    r = 22'd349526;
			6'd5:    r = 22'd419431;
			6'd4:    r = 22'd524288;
			6'd3:    r = 22'd699051;
			6'd2:    r = 22'd1048576;
			default: r = 22'd2097152;
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] width_mask(input logic [WID_W-1:0] w);
		logic [DATA_W-1:0] m;
		if (w >= 6'd32) begin
			m = '1;
		end else begin
			m = (DATA_W'(1) << w) - DATA_W'(1);
		end
		return m;
	endfunction

endpackage

// ===== hdl/pca_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
interface pca_req_if
	import pca_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	logic [IDX_W-1:0]   counter_index;
	logic [DATA_W-1:0]  value;
	logic [RANGE_W-1:0] range_count;

	modport source (output valid, req_type, counter_index, value, range_count, input ready);
	modport sink   (input valid, req_type, counter_index, value, range_count, output ready);
endinterface

// ===== hdl/pca_rsp_if.sv =====
// Response channel: valid/ready handshake with the result fields.
interface pca_rsp_if
	import pca_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_value;
	logic              status;

	modport source (output valid, read_value, status, input ready);
	modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== hdl/packed_counter_array.sv =====
// Packed counter array: variable-width counters packed into words of one RAM.
//
//  channel  dir  fields                                          handshake
//  req      in   req_type, counter_index, value, range_count     valid/ready
//  rsp      out  read_value, status                              valid/ready
//  cfg      in   cfg_index (0 width, 1 count), cfg_data          cfg_en
//
// Set or read: index split by reciprocal multiply (DIV, MUL, REM), one RAM read (RD), one
// update (UPD), then FIN; an out-of-range index goes from REM straight to FIN.
// Range increment: per word touched, one RAM read (RD), then one update (UPD) per counter.
// Fill: the pattern is built slot by slot (BUILD), then swept into every word (SWEEP); the RAM takes one word a cycle.
// After reset the RAM is cleared, every word in turn, with req.ready low.
// A waiting result sits in the output register; the next request is taken meanwhile
// and holds in its last cycle until the output register frees up.
module packed_counter_array
	import pca_pkg::*;
#(
	parameter int STORE_WORDS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	pca_req_if.sink           req,
	pca_rsp_if.source         rsp,
	input  logic              cfg_en,
	input  logic [0:0]        cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	localparam int AW   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int CAPW = $clog2(STORE_WORDS + 1) + WID_W;
	localparam logic [CAPW-1:0]  STORE_N = CAPW'(STORE_WORDS);
	localparam logic [AW-1:0]    LAST_WORD = AW'(STORE_WORDS - 1);
	localparam logic [CNT_W-1:0] CNT_RST =
		(STORE_WORDS * 4 < 4096) ? CNT_W'(STORE_WORDS * 4) : CNT_W'(4096);

	// configuration and derived values
	logic [CNT_W-1:0]  count_q;
	logic [WID_W-1:0]  w_q;
	logic [WID_W-1:0]  p_q;
	logic [DATA_W-1:0] mask_q;
	logic [RCP_W-1:0]  recip_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [WID_W-1:0]  cfg_w;
	logic [WID_W-1:0]  cfg_p;
	logic [CAPW-1:0]   cap_new;
	logic [CAPW-1:0]   cap_cur;

	always_comb begin
		if (cfg_data[WID_W-1:0] == '0) begin
			cfg_w = 6'd1;
		end else if (cfg_data[WID_W-1:0] > 6'd32) begin
			cfg_w = 6'd32;
		end else begin
			cfg_w = cfg_data[WID_W-1:0];
		end
		cfg_p   = per_word(cfg_w);
		cap_new = STORE_N * CAPW'(cfg_p);
		cap_cur = STORE_N * CAPW'(p_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd4096;
			w_q     <= 6'd8;
			p_q     <= 6'd4;
			mask_q  <= 32'h0000_00FF;
			recip_q <= 22'd524288;
			cnt_q   <= CNT_RST;
		end else if (cfg_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WIDTH: begin
					w_q     <= cfg_w;
					p_q     <= cfg_p;
					mask_q  <= width_mask(cfg_w);
					recip_q <= recip(cfg_p);
					cnt_q   <= (CAPW'(count_q) < cap_new) ? count_q : cap_new[CNT_W-1:0];
				end
				CFG_COUNT: begin
					count_q <= cfg_data;
					cnt_q   <= (CAPW'(cfg_data) < cap_cur) ? cfg_data : cap_cur[CNT_W-1:0];
				end
			endcase
		end
	end

	// sequencer state
	state_t            state_q;
	logic [AW-1:0]     sweep_q;
	logic              emit_q;
	logic [DATA_W-1:0] pat_q;
	logic              ov_q;

	// request and working registers
	req_kind_t          type_q;
	logic [IDX_W-1:0]   idx_q;
	logic [DATA_W-1:0]  val_q;
	logic [RANGE_W-1:0] rng_q;
	logic [CNT_W-1:0]   word_q;
	logic [IDX_W-1:0]   qp_q;
	logic [4:0]         slot_q;
	logic [4:0]         off_q;
	logic [CNT_W-1:0]   n_q;
	logic [DATA_W-1:0]  buf_q;
	logic               fresh_q;
	logic [4:0]         k_q;
	logic [4:0]         boff_q;
	logic [DATA_W-1:0]  res_rd_q;
	logic               res_st_q;
	logic [DATA_W-1:0]  ord_q;
	logic               ost_q;

	// datapath
	logic [IDX_W+RCP_W-1:0] prod;
	logic [21:0]            qp;
	logic [IDX_W-1:0]       rem;
	logic [10:0]            offm;
	logic                   idx_ok;
	logic [CNT_W:0]         sum;
	logic [CNT_W:0]         endc;
	logic [CNT_W:0]         nn;
	logic [DATA_W-1:0]      cur;
	logic [DATA_W-1:0]      field;
	logic [DATA_W-1:0]      hole;
	logic [DATA_W-1:0]      set_word;
	logic [DATA_W-1:0]      inc_word;
	logic                   last_slot;
	logic                   last_cnt;
	logic                   fin_go;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DATA_W-1:0]      ram_wdata;
	logic [DATA_W-1:0]      ram_rdata;

	always_comb begin
		prod      = (IDX_W+RCP_W)'(idx_q) * (IDX_W+RCP_W)'(recip_q);
		qp        = 22'(word_q) * 22'(p_q);
		rem       = idx_q - qp_q;
		offm      = 11'(rem[4:0]) * 11'(w_q);
		idx_ok    = CNT_W'(idx_q) < cnt_q;
		sum       = (CNT_W+1)'(idx_q) + (CNT_W+1)'(rng_q);
		endc      = (sum < (CNT_W+1)'(cnt_q)) ? sum : (CNT_W+1)'(cnt_q);
		nn        = endc - (CNT_W+1)'(idx_q);
		cur       = fresh_q ? ram_rdata : buf_q;
		field     = (cur >> off_q) & mask_q;
		hole      = cur & ~(mask_q << off_q);
		set_word  = hole | ((val_q & mask_q) << off_q);
		inc_word  = hole | (((field + DATA_W'(1)) & mask_q) << off_q);
		last_slot = WID_W'(slot_q) == (p_q - 6'd1);
		last_cnt  = n_q == 16'd1;
		fin_go    = !ov_q || rsp.ready;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(word_q);
		ram_wdata = inc_word;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = pat_q;
		end else if (state_q == ST_UPD) begin
			if (type_q == REQ_SET) begin
				ram_we    = 1'b1;
				ram_wdata = set_word;
			end else if (type_q == REQ_INC && (last_cnt || last_slot)) begin
				ram_we = 1'b1;
			end
		end
	end

	pca_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(word_q)),
		.rdata (ram_rdata)
	);

	// control: state, clear/fill sweep, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			emit_q  <= 1'b0;
			pat_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			// load a new word, else drop the one just taken
			if (state_q == ST_FIN && fin_go) begin
				ov_q <= 1'b1;
			end else if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (req_kind_t'(req.req_type) == REQ_FILL) begin
							pat_q   <= '0;
							state_q <= ST_BUILD;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_BUILD: begin
					// replicate the masked value into each slot of the word
					pat_q <= pat_q | ((val_q & mask_q) << boff_q);
					if (WID_W'(k_q) == p_q - 6'd1) begin
						sweep_q <= '0;
						emit_q  <= 1'b1;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_WORD) begin
						state_q <= emit_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_DIV: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_REM;
				ST_REM: begin
					unique case (type_q)
						REQ_SET, REQ_READ: state_q <= idx_ok ? ST_RD : ST_FIN;
						REQ_INC: state_q <= (idx_ok && rng_q != '0) ? ST_RD : ST_FIN;
						REQ_FILL: state_q <= ST_FIN;
					endcase
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD: begin
					if (type_q != REQ_INC || last_cnt) begin
						state_q <= ST_FIN;
					end else if (last_slot) begin
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				type_q   <= req_kind_t'(req.req_type);
				idx_q    <= req.counter_index;
				val_q    <= req.value;
				rng_q    <= req.range_count;
				k_q      <= '0;
				boff_q   <= '0;
				res_rd_q <= '0;
				res_st_q <= 1'b0;
			end
			ST_BUILD: begin
				k_q    <= k_q + 5'd1;
				boff_q <= 5'(boff_q + 5'(w_q));
			end
			ST_DIV: word_q <= CNT_W'(prod[IDX_W+RCP_W-1:RCP_SH]);
			ST_MUL: qp_q <= qp[IDX_W-1:0];
			ST_REM: begin
				slot_q   <= rem[4:0];
				off_q    <= offm[4:0];
				n_q      <= nn[CNT_W-1:0];
				res_st_q <= (type_q == REQ_SET || type_q == REQ_READ) && !idx_ok;
			end
			ST_RD: fresh_q <= 1'b1;
			ST_UPD: begin
				if (type_q == REQ_READ) begin
					res_rd_q <= field;
				end
				if (type_q == REQ_INC) begin
					n_q <= n_q - 16'd1;
					if (last_slot) begin
						// word done: step to the next one
						word_q <= word_q + 16'd1;
						slot_q <= '0;
						off_q  <= '0;
					end else begin
						buf_q   <= inc_word;
						fresh_q <= 1'b0;
						slot_q  <= slot_q + 5'd1;
						off_q   <= 5'(off_q + 5'(w_q));
					end
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					ord_q <= res_rd_q;
					ost_q <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready      = state_q == ST_IDLE;
	assign rsp.valid      = ov_q;
	assign rsp.read_value = ord_q;
	assign rsp.status     = ost_q;

endmodule

// ===== hdl/pca_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module pca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== verif/tb.sv =====
// Testbench for the packed counter array: random and directed requests vs. a shadow store.
`timescale 1ns / 1ps

module tb;
	import pca_pkg::*;

	localparam int RAM_WORDS = 1024;

	typedef struct packed {
		req_kind_t          kind;
		logic [IDX_W-1:0]   index;
		logic [DATA_W-1:0]  value;
		logic [RANGE_W-1:0] span;
	} req_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic              status;
	} rsp_word_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_en;
	logic [0:0]       cfg_index;
	logic [CNT_W-1:0] cfg_data;

	pca_req_if req_bus ();
	pca_rsp_if rsp_bus ();

	packed_counter_array #(
		.STORE_WORDS(RAM_WORDS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the counter store and its registers
	logic [DATA_W-1:0] shadow_words [RAM_WORDS];
	logic [WID_W-1:0]  shadow_width;
	logic [CNT_W-1:0]  shadow_count;

	req_word_t   pending_reqs [$];
	rsp_word_t   due_results [$];
	bit          req_fired;
	bit          rsp_hold;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned mismatches;
	int unsigned big_spans_left;
	logic [CNT_W-1:0] phase_width [12];
	logic [CNT_W-1:0] phase_count [12];

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned lane_width();
		if (shadow_width == '0) return 1;
		if (shadow_width > 6'd32) return 32;
		return 32'(shadow_width);
	endfunction

	function automatic logic [DATA_W-1:0] lane_mask(input int unsigned w);
		return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
	endfunction

	function automatic int unsigned live_count();
		int unsigned cap;
		int unsigned cnt_set;
		cap = RAM_WORDS * (32 / lane_width());
		cnt_set = 32'(shadow_count);
		return (cnt_set < cap) ? cnt_set : cap;
	endfunction

	function automatic logic [DATA_W-1:0] lane_get(input int unsigned idx);
		int unsigned w;
		int unsigned per;
		w = lane_width();
		per = 32 / w;
		return (shadow_words[idx / per] >> ((idx % per) * w)) & lane_mask(w);
	endfunction

	function automatic void lane_put(input int unsigned idx, input logic [DATA_W-1:0] v);
		int unsigned w;
		int unsigned per;
		int unsigned off;
		logic [DATA_W-1:0] m;
		w = lane_width();
		per = 32 / w;
		m = lane_mask(w);
		off = (idx % per) * w;
		shadow_words[idx / per] = (shadow_words[idx / per] & ~(m << off)) | ((v & m) << off);
	endfunction

	function automatic rsp_word_t apply_counter_op(input req_word_t r);
		rsp_word_t res;
		int unsigned w;
		int unsigned per;
		int unsigned cnt;
		int unsigned stop;
		int unsigned k;
		logic [DATA_W-1:0] fill_word;
		res = '0;
		w = lane_width();
		per = 32 / w;
		cnt = live_count();
		case (r.kind)
			REQ_FILL: begin
				fill_word = '0;
				for (k = 0; k < per; k++) fill_word |= (r.value & lane_mask(w)) << (k * w);
				for (k = 0; k < RAM_WORDS; k++) shadow_words[k] = fill_word;
			end
			REQ_SET: begin
				if (r.index < cnt) lane_put(r.index, r.value);
				else res.status = 1'b1;
			end
			REQ_READ: begin
				if (r.index < cnt) res.read_value = lane_get(r.index);
				else res.status = 1'b1;
			end
			default: begin
				if (r.span != '0 && r.index < cnt) begin
					stop = r.index + r.span;
					if (stop > cnt) stop = cnt;
					for (k = r.index; k < stop; k++) lane_put(k, lane_get(k) + 32'd1);
				end
			end
		endcase
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic queue_req(input req_kind_t k, input int unsigned idx,
			input logic [DATA_W-1:0] v, input int unsigned span);
		req_word_t item;
		item.kind = k;
		item.index = IDX_W'(idx);
		item.value = v;
		item.span = RANGE_W'(span);
		pending_reqs.push_back(item);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CNT_W-1:0] d);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(negedge clk);
		cfg_en <= 1'b0;
		if (r == CFG_WIDTH) shadow_width = d[WID_W-1:0];
		else shadow_count = d;
	endtask

	// hold until every word is sent and every result is back
	task automatic drain();
		while (pending_reqs.size() != 0 || req_bus.valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// request driver and response ready, both on the falling edge
	always @(negedge clk) begin
		req_word_t nxt;
		if (arst_n && (!req_bus.valid || req_fired)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.req_type <= nxt.kind;
				req_bus.counter_index <= nxt.index;
				req_bus.value <= nxt.value;
				req_bus.range_count <= nxt.span;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
		rsp_bus.ready <= arst_n && !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin
		req_word_t seen;
		rsp_word_t want;
		req_fired = req_bus.valid && req_bus.ready;
		if (req_fired) begin
			seen.kind = req_kind_t'(req_bus.req_type);
			seen.index = req_bus.counter_index;
			seen.value = req_bus.value;
			seen.span = req_bus.range_count;
			due_results.push_back(apply_counter_op(seen));
			words_in++;
		end
		if (rsp_bus.valid && rsp_bus.ready) begin
			words_out++;
			if (due_results.size() == 0) begin
				flag_mismatch($sformatf("response %0d with nothing outstanding", words_out));
			end else begin
				want = due_results.pop_front();
				if (rsp_bus.read_value !== want.read_value)
					flag_mismatch($sformatf("response %0d read_value %h, predicted %h",
						words_out, rsp_bus.read_value, want.read_value));
				if (rsp_bus.status !== want.status)
					flag_mismatch($sformatf("response %0d status %b, predicted %b",
						words_out, rsp_bus.status, want.status));
			end
		end
	end

	// long receiver stall so the block backs up onto its request side
	initial begin
		rsp_hold = 1'b0;
		wait (words_in >= 60);
		rsp_hold = 1'b1;
		repeat (300) @(posedge clk);
		rsp_hold = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("FAIL packed_counter_array");
		$finish;
	end

	initial begin
		req_word_t item;
		int unsigned cnt;
		int unsigned hot;
		int unsigned roll;
		int unsigned pick;

		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_FILL;
		req_bus.counter_index = '0;
		req_bus.value = '0;
		req_bus.range_count = '0;
		rsp_bus.ready = 1'b0;
		req_fired = 1'b0;
		words_in = 0;
		words_out = 0;
		mismatches = 0;
		big_spans_left = 8;
		send_idle_pct = 24;
		recv_idle_pct = 71;
		for (int k = 0; k < RAM_WORDS; k++) shadow_words[k] = '0;
		shadow_width = 6'd8;
		shadow_count = 16'd4096;

		phase_width = '{16'd1, 16'd32, 16'd3, 16'd0, 16'd63, 16'd5,
			16'd12, 16'd1, 16'd16, 16'd7, 16'd8, 16'd8};
		phase_count = '{16'd32768, 16'd65535, 16'd10240, 16'd100, 16'd50, 16'd0,
			16'd2048, 16'd65535, 16'd1, 16'd4096, 16'd4096, 16'd4096};
		phase_width[10] = CNT_W'($urandom_range(1, 32));
		phase_count[10] = CNT_W'($urandom_range(1, 65535));
		phase_width[11] = CNT_W'($urandom_range(1, 32));
		phase_count[11] = CNT_W'($urandom_range(1, 65535));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pass at reset settings: 8-bit counters, 4096 of them
		queue_req(REQ_READ, 0, 32'h0, 0);
		queue_req(REQ_SET, 0, 32'hFFFF_FFFF, 0);
		queue_req(REQ_READ, 0, 32'h0, 0);
		queue_req(REQ_INC, 0, 32'h0, 2);
		queue_req(REQ_READ, 0, 32'h0, 0);
		queue_req(REQ_READ, 1, 32'h0, 0);
		queue_req(REQ_SET, 4095, 32'h5A, 0);
		queue_req(REQ_READ, 4095, 32'h0, 0);
		queue_req(REQ_SET, 4096, 32'h33, 0);
		queue_req(REQ_READ, 4096, 32'h0, 0);
		queue_req(REQ_READ, 32767, 32'h0, 0);
		queue_req(REQ_INC, 0, 32'h0, 0);
		queue_req(REQ_INC, 4096, 32'h0, 5);
		queue_req(REQ_INC, 4093, 32'h0, 32768);
		queue_req(REQ_READ, 4095, 32'h0, 0);
		queue_req(REQ_FILL, 0, 32'hFFFF_FFFF, 0);
		queue_req(REQ_READ, 2049, 32'h0, 0);
		queue_req(REQ_FILL, 0, 32'h1234_5678, 0);
		queue_req(REQ_INC, 0, 32'h0, 32768);
		queue_req(REQ_READ, 4095, 32'h0, 0);
		queue_req(REQ_READ, 0, 32'h0, 0);

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			if (ph == 4) begin
				send_idle_pct = 71;
				recv_idle_pct = 24;
			end
			if (ph == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_WIDTH, phase_width[ph]);
			write_reg(CFG_COUNT, phase_count[ph]);
			cnt = live_count();
			hot = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
			// fill after the width change, at widths that leave unused top bits in each word
			if (ph == 2 || ph == 6) queue_req(REQ_FILL, 0, $urandom(), 0);
			for (int n = 0; n < 53; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) item.kind = REQ_FILL;
				else if (roll < 33) item.kind = REQ_SET;
				else if (roll < 66) item.kind = REQ_READ;
				else item.kind = REQ_INC;

				roll = $urandom_range(0, 99);
				if (cnt == 0 || roll < 15) begin
					pick = $urandom_range(0, 32767);
				end else if (roll < 25) begin
					pick = cnt - 1 + $urandom_range(0, 1);
				end else if (roll < 65) begin
					pick = hot + $urandom_range(0, 63);
					if (pick >= cnt) pick = cnt - 1;
				end else begin
					pick = $urandom_range(0, cnt - 1);
				end
				if (pick > 32767) pick = 32767;
				item.index = IDX_W'(pick);
				item.value = $urandom();

				// keep whole-store ranges rare, they take one update step per counter
				roll = $urandom_range(0, 99);
				if (item.kind == REQ_INC && big_spans_left > 0 && roll < 2) begin
					big_spans_left--;
					item.span = RANGE_W'($urandom_range(0, 32768));
				end else if (roll < 12) begin
					item.span = '0;
				end else if (roll < 85) begin
					item.span = RANGE_W'($urandom_range(1, 16));
				end else begin
					item.span = RANGE_W'($urandom_range(17, 300));
				end
				pending_reqs.push_back(item);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (due_results.size() != 0)
			flag_mismatch($sformatf("%0d responses never arrived", due_results.size()));
		if (mismatches == 0) begin
			$display("PASS packed_counter_array");
		end else begin
			$display("FAIL packed_counter_array");
		end
		$finish;
	end

endmodule
